[design/smp_pkg.sv]
// shared types and constants of the square matrix power block
package smp_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int EXP_W  = 31;
    localparam int DIM_W  = 4;
    localparam int ADDR_W = 3;

    localparam logic [DIM_W-1:0]  DIM_RESET = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_DIM  = 3'd0;
    localparam logic              KIND_LOAD = 1'b0;
    localparam logic              KIND_POW  = 1'b1;

    // control broadcast to every cell
    typedef struct packed {
        logic             init;
        logic             sq;
        logic             use_base;
        logic [DIM_W-1:0] dim;
    } t_ctl;

    // partial sum travelling along the chain
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [IDX_W-1:0]  i;
        logic [IDX_W-1:0]  j;
        logic [DATA_W-1:0] acc;
    } t_tok;

    // finished element written back into the cells
    typedef struct packed {
        logic              vld;
        logic              to_r;
        logic [IDX_W-1:0]  i;
        logic [IDX_W-1:0]  j;
        logic [DATA_W-1:0] data;
    } t_wr;

    // base element load
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] data;
    } t_ld;

endpackage

[design/smp_if.sv]
// stream interfaces for input items and result elements
interface smp_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] element;
    logic [30:0]        exponent;

    modport source (output valid, kind, row, col, element, exponent, input ready);
    modport sink   (input valid, kind, row, col, element, exponent, output ready);
endinterface

interface smp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, out_row, out_col, value, last, input ready);
    modport sink   (input valid, out_row, out_col, value, last, output ready);
endinterface

[design/smp_cell.sv]
// one multiply-accumulate cell of the chain, owning row and column k of the operands
module smp_cell #(
    parameter int MAX_DIM = 8,
    parameter int K       = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  smp_pkg::t_ctl             i_ctl,
    input  smp_pkg::t_tok             i_tok,
    output smp_pkg::t_tok             o_tok,
    input  smp_pkg::t_wr              i_wr,
    input  smp_pkg::t_ld              i_ld,
    output logic [smp_pkg::DATA_W-1:0] o_rrow [MAX_DIM]
);
    import smp_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [IDX_W-1:0] KI = IDX_W'(K);
    localparam logic [DIM_W-1:0] KD = DIM_W'(K);

    logic [DATA_W-1:0] r_base [MAX_DIM];   // base row k
    logic [DATA_W-1:0] r_rrow [MAX_DIM];   // running product row k
    logic [DATA_W-1:0] r_rcol [MAX_DIM];   // running product column k
    logic [DATA_W-1:0] r_scol [MAX_DIM];   // square column k
    t_tok              r_tok;
    t_tok              n_tok;
    logic [DATA_W-1:0] w_a;
    logic [DATA_W-1:0] w_b;
    logic [DATA_W-1:0] w_prod;

    // operand select: square uses r*r, multiply uses s*base or s*identity
    always_comb begin
        w_a = i_ctl.sq ? r_rcol[i_tok.i[IW-1:0]] : r_scol[i_tok.i[IW-1:0]];
        if (i_ctl.sq) begin
            w_b = r_rrow[i_tok.j[IW-1:0]];
        end else if (i_ctl.use_base) begin
            w_b = r_base[i_tok.j[IW-1:0]];
        end else begin
            w_b = (i_tok.j == KI) ? DATA_W'(1) : '0;
        end
        w_prod = w_a * w_b;
        n_tok  = i_tok;
        if (KD < i_ctl.dim) begin
            n_tok.acc = i_tok.acc + w_prod;
        end
    end

    // chain stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // base row, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                r_base[c] <= '0;
            end
        end else if (i_ld.vld && i_ld.row == KI) begin
            r_base[i_ld.col[IW-1:0]] <= i_ld.data;
        end
    end

    // working products: identity load and write-back
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                r_rrow[c] <= (c == K) ? DATA_W'(1) : '0;
                r_rcol[c] <= (c == K) ? DATA_W'(1) : '0;
            end
        end else if (i_wr.vld) begin
            if (i_wr.to_r) begin
                if (i_wr.i == KI) begin
                    r_rrow[i_wr.j[IW-1:0]] <= i_wr.data;
                end
                if (i_wr.j == KI) begin
                    r_rcol[i_wr.i[IW-1:0]] <= i_wr.data;
                end
            end else if (i_wr.j == KI) begin
                r_scol[i_wr.i[IW-1:0]] <= i_wr.data;
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_rrow = r_rrow;

endmodule

[design/square_matrix_power_top.sv]
// top level of the square matrix power block: control, chain and result stream
// A load transaction writes one base element if its row and column lie below MAX_DIM.
// A compute transaction runs 31 bit steps of the exponent, each a squaring pass and a
// multiply pass over a chain of MAX_DIM multiply-accumulate cells; a pass issues d*d
// elements one per cycle and ends when the last one leaves the chain. After the last
// pass the d*d result elements stream out one per cycle while the receiver is ready,
// the last one marked. New transactions are taken once the last element sits in the
// output register. The base matrix is cleared by reset.
module square_matrix_power_top #(
    parameter int MAX_DIM = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    smp_in_if.sink                     i_in,
    smp_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [smp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import smp_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [DIM_W-1:0] DMAX = DIM_W'(MAX_DIM);

    logic [2:0]        r_state;
    logic [DIM_W-1:0]  r_dim;
    logic [DIM_W-1:0]  r_d;
    logic [EXP_W-1:0]  r_exp;
    logic [4:0]        r_bit;
    logic [IDX_W-1:0]  r_ii;
    logic [IDX_W-1:0]  r_jj;
    logic              r_iss_done;
    logic              r_ovld;
    logic [IDX_W-1:0]  r_orow;
    logic [IDX_W-1:0]  r_ocol;
    logic [DATA_W-1:0] r_oval;
    logic              r_olast;
    logic [IDX_W-1:0]  w_dm1;
    logic [DIM_W-1:0]  w_act;
    logic              w_acc_in;
    logic              w_cfg_wr;
    logic              w_iss_last;
    logic              w_oload;
    t_ctl              w_ctl;
    t_ld               w_ld;
    t_wr               w_wr;
    t_tok              w_tok [MAX_DIM+1];
    logic [DATA_W-1:0] w_rrow [MAX_DIM][MAX_DIM];

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_DIM);
    assign prdata   = (paddr == ADDR_DIM) ? {28'd0, r_dim} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (w_cfg_wr) begin
            r_dim <= pwdata[DIM_W-1:0];
        end
    end

    // dimension in use
    always_comb begin
        if (r_dim == '0) begin
            w_act = DIM_W'(1);
        end else if (r_dim > DMAX) begin
            w_act = DMAX;
        end else begin
            w_act = r_dim;
        end
    end
    assign w_dm1 = IDX_W'(r_d - DIM_W'(1));

    // input handshake and base loads
    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc_in   = i_in.valid && i_in.ready;
    always_comb begin
        w_ld.vld  = w_acc_in && (i_in.kind == KIND_LOAD) &&
                    (DIM_W'(i_in.row) < DMAX) && (DIM_W'(i_in.col) < DMAX);
        w_ld.row  = i_in.row;
        w_ld.col  = i_in.col;
        w_ld.data = i_in.element;
    end

    // cell control and element issue into the chain
    assign w_iss_last = (r_ii == w_dm1) && (r_jj == w_dm1);
    always_comb begin
        w_ctl.init     = (r_state == S_INIT);
        w_ctl.sq       = (r_state == S_SQ);
        w_ctl.use_base = r_exp[r_bit];
        w_ctl.dim      = r_d;
        w_tok[0].vld   = ((r_state == S_SQ) || (r_state == S_MUL)) && !r_iss_done;
        w_tok[0].last  = w_iss_last;
        w_tok[0].i     = r_ii;
        w_tok[0].j     = r_jj;
        w_tok[0].acc   = '0;
    end

    // write-back from the chain end
    always_comb begin
        w_wr.vld  = w_tok[MAX_DIM].vld;
        w_wr.to_r = (r_state == S_MUL);
        w_wr.i    = w_tok[MAX_DIM].i;
        w_wr.j    = w_tok[MAX_DIM].j;
        w_wr.data = w_tok[MAX_DIM].acc;
    end

    // chain of cells
    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        smp_cell #(
            .MAX_DIM (MAX_DIM),
            .K       (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1]),
            .i_wr    (w_wr),
            .i_ld    (w_ld),
            .o_rrow  (w_rrow[k])
        );
    end

    assign w_oload = (r_state == S_EMIT) && (!r_ovld || o_out.ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_iss_done <= 1'b0;
            r_ii       <= '0;
            r_jj       <= '0;
            r_bit      <= '0;
        end else begin
            unique case (r_state) inside
                S_IDLE: begin
                    if (w_acc_in && i_in.kind == KIND_POW) begin
                        r_exp   <= i_in.exponent;
                        r_d     <= w_act;
                        r_bit   <= 5'(EXP_W - 1);
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_ii       <= '0;
                    r_jj       <= '0;
                    r_iss_done <= 1'b0;
                    r_state    <= S_SQ;
                end
                S_SQ, S_MUL: begin
                    if (!r_iss_done) begin
                        if (w_iss_last) begin
                            r_iss_done <= 1'b1;
                        end else if (r_jj == w_dm1) begin
                            r_jj <= '0;
                            r_ii <= r_ii + IDX_W'(1);
                        end else begin
                            r_jj <= r_jj + IDX_W'(1);
                        end
                    end
                    if (w_wr.vld && w_tok[MAX_DIM].last) begin
                        r_ii       <= '0;
                        r_jj       <= '0;
                        r_iss_done <= 1'b0;
                        if (r_state == S_SQ) begin
                            r_state <= S_MUL;
                        end else if (r_bit == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_bit   <= r_bit - 5'd1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_oload) begin
                        if (w_iss_last) begin
                            r_state <= S_IDLE;
                        end else if (r_jj == w_dm1) begin
                            r_jj <= '0;
                            r_ii <= r_ii + IDX_W'(1);
                        end else begin
                            r_jj <= r_jj + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_oload) begin
            r_ovld <= 1'b1;
        end else if (o_out.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_orow  <= r_ii;
            r_ocol  <= r_jj;
            r_oval  <= w_rrow[r_ii[IW-1:0]][r_jj[IW-1:0]];
            r_olast <= w_iss_last;
        end
    end

    assign o_out.valid   = r_ovld;
    assign o_out.out_row = r_orow;
    assign o_out.out_col = r_ocol;
    assign o_out.value   = r_oval;
    assign o_out.last    = r_olast;

    // checks
    a_wb_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_DIM].vld |-> (r_state == S_SQ || r_state == S_MUL))
        else $error("write-back outside a pass");

    a_idle_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_tok[MAX_DIM].vld && !w_tok[0].vld)
        else $error("chain busy while taking input");

    a_issue_in_dim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[0].vld |-> (DIM_W'(r_ii) < r_d) && (DIM_W'(r_jj) < r_d))
        else $error("issued element outside dimension");

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld && !(r_state == S_EMIT) |=> !r_ovld)
        else $error("result outside emit");

endmodule
